### src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent in one cycle, consequent in the next
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### src/ipc_pkg.sv
package ipc_pkg;

    localparam int VECTOR_COUNT_DEF = 256;
    localparam int QUEUE_DEPTH      = 2;
    localparam int ROW_BITS         = 32;
    localparam int BIT_W            = 5;
    localparam logic [7:0] LEGAL_MIN = 8'd16;

    typedef enum logic [1:0] {
        ACT_PEND  = 2'd0,
        ACT_ACK   = 2'd1,
        ACT_EOI   = 2'd2,
        ACT_QUERY = 2'd3
    } action_t;

    typedef struct packed {
        action_t    act;
        logic [7:0] vec;
        logic       ie;
        logic [3:0] tpr;
        logic       illegal;
        logic       in_range;
    } item_t;

    // interrupts must be enabled, and the class must beat the task priority and the class in service
    function automatic logic vec_allowed(logic [7:0] vec, logic ie, logic [3:0] tpr,
                                         logic srv_valid, logic [7:0] srv_vec);
        vec_allowed = ie && (vec[7:4] > tpr) && (!srv_valid || (vec[7:4] > srv_vec[7:4]));
    endfunction

endpackage

### src/ipc_front.sv
module ipc_front import ipc_pkg::*; #(
    parameter int VECTOR_COUNT = VECTOR_COUNT_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] action,
    input  logic [7:0] vector,
    input  logic       interrupts_enabled,
    input  logic [3:0] task_priority,
    input  logic       q_full,
    output logic       push,
    output item_t      push_item
);

    logic  valid_reg, valid_next;
    item_t item_reg;
    logic  take;

    assign busy      = valid_reg && q_full;
    assign take      = start && !busy;
    assign push      = valid_reg && !q_full;
    assign push_item = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // classify on the way in
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.act      <= action_t'(action);
            item_reg.vec      <= vector;
            item_reg.ie       <= interrupts_enabled;
            item_reg.tpr      <= task_priority;
            item_reg.illegal  <= (vector < LEGAL_MIN);
            item_reg.in_range <= ({1'b0, vector} < 9'(VECTOR_COUNT));
        end
    end

endmodule

### src/ipc_queue.sv
module ipc_queue import ipc_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  empty,
    output item_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t              mem [DEPTH];
    logic [PTR_W-1:0]   wr_reg, wr_next, rd_reg, rd_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    assign full  = (cnt_reg == CNT_W'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = mem[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wr_next = (wr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_next = (rd_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= push_item;
        end
    end

endmodule

### src/ipc_back.sv
module ipc_back import ipc_pkg::*; #(
    parameter int VECTOR_COUNT = VECTOR_COUNT_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_empty,
    input  item_t      head,
    output logic       pop,
    output logic       done,
    output logic       delivered,
    output logic [7:0] delivered_vector,
    output logic       would_accept,
    output logic       illegal_vector_seen,
    output logic       pending_any,
    output logic [7:0] highest_pending,
    output logic       in_service_any,
    output logic [7:0] highest_in_service
);

    localparam int ROWS  = (VECTOR_COUNT + ROW_BITS - 1) / ROW_BITS;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int IDX_W = ROW_W + BIT_W;

    typedef enum logic [4:0] {
        B_IDLE = 5'b00001,
        B_EXEC = 5'b00010,
        B_ROW  = 5'b00100,
        B_BIT  = 5'b01000,
        B_DONE = 5'b10000
    } bstate_t;

    bstate_t state_reg, state_next;
    item_t   cur_reg;

    logic [ROW_BITS-1:0] req_reg [ROWS];
    logic [ROW_BITS-1:0] req_next [ROWS];
    logic [ROW_BITS-1:0] srv_reg [ROWS];
    logic [ROW_BITS-1:0] srv_next [ROWS];

    logic       treq_v_reg, treq_v_next, tsrv_v_reg, tsrv_v_next;
    logic [7:0] treq_reg, treq_next, tsrv_reg, tsrv_next;
    logic       err_reg, err_next;
    logic       dlv_reg, dlv_next, acc_reg, acc_next;
    logic [7:0] dvec_reg, dvec_next;

    logic [ROW_W-1:0] rrow_reg, rrow_next, srow_reg, srow_next;
    logic             rany_reg, rany_next, sany_reg, sany_next;

    logic [IDX_W-1:0] cur_idx, treq_idx, tsrv_idx;
    logic             ack_ok;
    logic [BIT_W-1:0] rbit, sbit;
    logic [ROW_BITS-1:0] rsel, ssel;

    assign pop      = ((state_reg == B_IDLE) || (state_reg == B_DONE)) && !q_empty;
    assign cur_idx  = IDX_W'(cur_reg.vec);
    assign treq_idx = IDX_W'(treq_reg);
    assign tsrv_idx = IDX_W'(tsrv_reg);
    assign ack_ok   = treq_v_reg && vec_allowed(treq_reg, cur_reg.ie, cur_reg.tpr,
                                                tsrv_v_reg, tsrv_reg);
    assign rsel     = req_reg[rrow_reg];
    assign ssel     = srv_reg[srow_reg];

    assign done                = (state_reg == B_DONE);
    assign delivered           = dlv_reg;
    assign delivered_vector    = dvec_reg;
    assign would_accept        = acc_reg;
    assign illegal_vector_seen = err_reg;
    assign pending_any         = treq_v_reg;
    assign highest_pending     = treq_reg;
    assign in_service_any      = tsrv_v_reg;
    assign highest_in_service  = tsrv_reg;

    // highest set bit of the selected rows
    always_comb
    begin
        rbit = '0;
        sbit = '0;
        for (int b = 0; b < ROW_BITS; b++)
        begin
            if (rsel[b])
            begin
                rbit = BIT_W'(b);
            end
            if (ssel[b])
            begin
                sbit = BIT_W'(b);
            end
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        req_next    = req_reg;
        srv_next    = srv_reg;
        treq_v_next = treq_v_reg;
        treq_next   = treq_reg;
        tsrv_v_next = tsrv_v_reg;
        tsrv_next   = tsrv_reg;
        err_next    = err_reg;
        dlv_next    = dlv_reg;
        dvec_next   = dvec_reg;
        acc_next    = acc_reg;
        rrow_next   = rrow_reg;
        srow_next   = srow_reg;
        rany_next   = rany_reg;
        sany_next   = sany_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (pop)
                begin
                    state_next = B_EXEC;
                end
            end
            B_EXEC:
            begin
                dlv_next   = 1'b0;
                dvec_next  = '0;
                acc_next   = 1'b0;
                state_next = B_DONE;
                case (cur_reg.act)
                    ACT_PEND:
                    begin
                        if (cur_reg.illegal)
                        begin
                            err_next = 1'b1;
                        end
                        else if (cur_reg.in_range)
                        begin
                            req_next[cur_idx[IDX_W-1:BIT_W]][cur_idx[BIT_W-1:0]] = 1'b1;
                            state_next = B_ROW;
                        end
                    end
                    ACT_ACK:
                    begin
                        if (ack_ok)
                        begin
                            srv_next[treq_idx[IDX_W-1:BIT_W]][treq_idx[BIT_W-1:0]] = 1'b1;
                            req_next[treq_idx[IDX_W-1:BIT_W]][treq_idx[BIT_W-1:0]] = 1'b0;
                            dlv_next   = 1'b1;
                            dvec_next  = treq_reg;
                            state_next = B_ROW;
                        end
                    end
                    ACT_EOI:
                    begin
                        if (tsrv_v_reg)
                        begin
                            srv_next[tsrv_idx[IDX_W-1:BIT_W]][tsrv_idx[BIT_W-1:0]] = 1'b0;
                            state_next = B_ROW;
                        end
                    end
                    ACT_QUERY:
                    begin
                        acc_next = vec_allowed(cur_reg.vec, cur_reg.ie, cur_reg.tpr,
                                               tsrv_v_reg, tsrv_reg);
                    end
                    default:
                    begin
                        state_next = B_DONE;
                    end
                endcase
            end
            B_ROW:
            begin
                // highest nonzero row of each bitmap
                rany_next = 1'b0;
                sany_next = 1'b0;
                rrow_next = '0;
                srow_next = '0;
                for (int r = 0; r < ROWS; r++)
                begin
                    if (|req_reg[r])
                    begin
                        rany_next = 1'b1;
                        rrow_next = ROW_W'(r);
                    end
                    if (|srv_reg[r])
                    begin
                        sany_next = 1'b1;
                        srow_next = ROW_W'(r);
                    end
                end
                state_next = B_BIT;
            end
            B_BIT:
            begin
                treq_v_next = rany_reg;
                treq_next   = rany_reg ? 8'({rrow_reg, rbit}) : 8'd0;
                tsrv_v_next = sany_reg;
                tsrv_next   = sany_reg ? 8'({srow_reg, sbit}) : 8'd0;
                state_next  = B_DONE;
            end
            B_DONE:
            begin
                state_next = pop ? B_EXEC : B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            for (int r = 0; r < ROWS; r++)
            begin
                req_reg[r] <= '0;
                srv_reg[r] <= '0;
            end
            treq_v_reg <= 1'b0;
            treq_reg   <= '0;
            tsrv_v_reg <= 1'b0;
            tsrv_reg   <= '0;
            err_reg    <= 1'b0;
            dlv_reg    <= 1'b0;
            dvec_reg   <= '0;
            acc_reg    <= 1'b0;
            rany_reg   <= 1'b0;
            sany_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            req_reg    <= req_next;
            srv_reg    <= srv_next;
            treq_v_reg <= treq_v_next;
            treq_reg   <= treq_next;
            tsrv_v_reg <= tsrv_v_next;
            tsrv_reg   <= tsrv_next;
            err_reg    <= err_next;
            dlv_reg    <= dlv_next;
            dvec_reg   <= dvec_next;
            acc_reg    <= acc_next;
            rany_reg   <= rany_next;
            sany_reg   <= sany_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rrow_reg <= rrow_next;
        srow_reg <= srow_next;
        if (pop)
        begin
            cur_reg <= head;
        end
    end

endmodule

### src/interrupt_priority_controller.sv
// channel   direction  handshake        payload
// command   in         start, busy      action, vector, interrupts_enabled, task_priority
// result    out        done (strobe)    delivered, delivered_vector, would_accept,
//                                       illegal_vector_seen, pending_any, highest_pending,
//                                       in_service_any, highest_in_service
//
// a command is taken when start is high and busy is low; busy rises only while the
// input register holds a command and the two-entry queue is full
// the execution engine goes from execute straight to result for a query, a blocked
// acknowledge, an empty end of interrupt or an illegal or out-of-range pend, and through
// update, row search, bit search and result for a bitmap update; it pops the next command
// only in idle or result, so it does not start a command before the last one is through
// done is high for one cycle per command, in command order; the receiver cannot stall
// reset clears both bitmaps, the top registers and the error flag at once
module interrupt_priority_controller import ipc_pkg::*; #(
    parameter int VECTOR_COUNT = VECTOR_COUNT_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] action,
    input  logic [7:0] vector,
    input  logic       interrupts_enabled,
    input  logic [3:0] task_priority,
    output logic       done,
    output logic       delivered,
    output logic [7:0] delivered_vector,
    output logic       would_accept,
    output logic       illegal_vector_seen,
    output logic       pending_any,
    output logic [7:0] highest_pending,
    output logic       in_service_any,
    output logic [7:0] highest_in_service
);

    logic  q_full, q_empty, push, pop;
    item_t push_item, head;

    ipc_front #(
        .VECTOR_COUNT(VECTOR_COUNT)
    ) u_front (
        .clk                (clk),
        .rst_n              (rst_n),
        .start              (start),
        .busy               (busy),
        .action             (action),
        .vector             (vector),
        .interrupts_enabled (interrupts_enabled),
        .task_priority      (task_priority),
        .q_full             (q_full),
        .push               (push),
        .push_item          (push_item)
    );

    ipc_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .empty     (q_empty),
        .head      (head)
    );

    ipc_back #(
        .VECTOR_COUNT(VECTOR_COUNT)
    ) u_back (
        .clk                 (clk),
        .rst_n               (rst_n),
        .q_empty             (q_empty),
        .head                (head),
        .pop                 (pop),
        .done                (done),
        .delivered           (delivered),
        .delivered_vector    (delivered_vector),
        .would_accept        (would_accept),
        .illegal_vector_seen (illegal_vector_seen),
        .pending_any         (pending_any),
        .highest_pending     (highest_pending),
        .in_service_any      (in_service_any),
        .highest_in_service  (highest_in_service)
    );

endmodule

### src/ipc_checker.sv
`include "assert_macros.svh"

module ipc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       done,
    input logic       delivered,
    input logic [7:0] delivered_vector,
    input logic       would_accept,
    input logic       pending_any,
    input logic [7:0] highest_pending,
    input logic       in_service_any,
    input logic [7:0] highest_in_service
);

    // a delivered vector is the new top of service
    `ASSERT_PROP(a_deliver_in_service, clk, rst_n,
        done && delivered |-> in_service_any && highest_in_service == delivered_vector,
        "delivered vector is not the top in service")
    `ASSERT_PROP(a_deliver_class, clk, rst_n,
        done && delivered |-> delivered_vector[7:4] != 4'd0 && !would_accept,
        "delivered vector of class zero or with query outcome")
    `ASSERT_PROP(a_pending_zero, clk, rst_n,
        done && !pending_any |-> highest_pending == 8'd0,
        "highest pending not zero with nothing pending")
    `ASSERT_PROP(a_service_zero, clk, rst_n,
        done && !in_service_any |-> highest_in_service == 8'd0 && !delivered,
        "in-service report inconsistent")
    `ASSERT_NEXT(a_done_gap, clk, rst_n, done, !done, "result strobes back to back")

endmodule

bind interrupt_priority_controller ipc_checker u_checker (.*);

### dv/tb_interrupt_priority_controller.sv
module tb_interrupt_priority_controller;
    timeunit 1ns;
    timeprecision 1ps;

    import ipc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic       delivered;
        logic [7:0] dvec;
        logic       accept;
        logic       err;
        logic       pend_any;
        logic [7:0] top_pend;
        logic       srv_any;
        logic [7:0] top_srv;
    } outcome_t;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic [1:0] action;
    logic [7:0] vector;
    logic       interrupts_enabled;
    logic [3:0] task_priority;
    logic       done;
    logic       delivered;
    logic [7:0] delivered_vector;
    logic       would_accept;
    logic       illegal_vector_seen;
    logic       pending_any;
    logic [7:0] highest_pending;
    logic       in_service_any;
    logic [7:0] highest_in_service;

    // shadow of the controller state
    logic [255:0] request_map;
    logic [255:0] service_map;
    logic         err_sticky;

    outcome_t    outcomes_in_flight[$];
    int          sent_count;
    int          checked_count;
    int          delivery_count;
    int          accept_count;
    int          error_count;
    int          report_count;
    int unsigned cycle_count;
    bit          idle_enabled;

    interrupt_priority_controller uut (
        .clk                (clk),
        .rst_n              (rst_n),
        .start              (start),
        .busy               (busy),
        .action             (action),
        .vector             (vector),
        .interrupts_enabled (interrupts_enabled),
        .task_priority      (task_priority),
        .done               (done),
        .delivered          (delivered),
        .delivered_vector   (delivered_vector),
        .would_accept       (would_accept),
        .illegal_vector_seen(illegal_vector_seen),
        .pending_any        (pending_any),
        .highest_pending    (highest_pending),
        .in_service_any     (in_service_any),
        .highest_in_service (highest_in_service)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // returns {valid, vector} of the highest set bit
    function automatic logic [8:0] highest_set(logic [255:0] map);
        logic [8:0] top;
        top = '0;
        for (int v = 0; v < 256; v++)
        begin
            if (map[v])
                top = {1'b1, 8'(v)};
        end
        return top;
    endfunction

    function automatic logic class_allowed(logic [7:0] vec, logic ie, logic [3:0] tpr);
        logic [8:0] srv;
        srv = highest_set(service_map);
        return ie && (vec[7:4] > tpr) && (!srv[8] || (vec[7:4] > srv[7:4]));
    endfunction

    // updates the shadow state for one event and returns the outcome it must produce
    function automatic outcome_t apply_event(action_t act, logic [7:0] vec, logic ie,
                                             logic [3:0] tpr);
        outcome_t   o;
        logic [8:0] top;
        o = '0;
        case (act)
            ACT_PEND:
            begin
                if (vec < LEGAL_MIN)
                    err_sticky = 1'b1;
                else
                    request_map[vec] = 1'b1;
            end
            ACT_ACK:
            begin
                top = highest_set(request_map);
                if (top[8] && class_allowed(top[7:0], ie, tpr))
                begin
                    request_map[top[7:0]] = 1'b0;
                    service_map[top[7:0]] = 1'b1;
                    o.delivered = 1'b1;
                    o.dvec = top[7:0];
                end
            end
            ACT_EOI:
            begin
                top = highest_set(service_map);
                if (top[8])
                    service_map[top[7:0]] = 1'b0;
            end
            default:
                o.accept = class_allowed(vec, ie, tpr);
        endcase
        o.err = err_sticky;
        top = highest_set(request_map);
        o.pend_any = top[8];
        o.top_pend = top[8] ? top[7:0] : 8'h00;
        top = highest_set(service_map);
        o.srv_any = top[8];
        o.top_srv = top[8] ? top[7:0] : 8'h00;
        return o;
    endfunction

    // drives one event at the falling edge and holds it until the transfer
    task automatic send_event(action_t act, logic [7:0] vec, logic ie, logic [3:0] tpr);
        while (idle_enabled && $urandom_range(99) < 28)
        begin
            start = 1'b0;
            action = 2'($urandom);
            vector = 8'($urandom);
            interrupts_enabled = 1'($urandom);
            task_priority = 4'($urandom);
            @(negedge clk);
        end
        start = 1'b1;
        action = act;
        vector = vec;
        interrupts_enabled = ie;
        task_priority = tpr;
        do
            @(posedge clk);
        while (busy);
        outcomes_in_flight.push_back(apply_event(act, vec, ie, tpr));
        sent_count++;
        @(negedge clk);
    endtask

    task automatic test_empty_events();
        send_event(ACT_ACK, 8'h00, 1'b1, 4'h0);
        send_event(ACT_EOI, 8'h00, 1'b1, 4'h0);
        // a class-zero vector can never be accepted
        send_event(ACT_QUERY, 8'h0F, 1'b1, 4'h0);
        send_event(ACT_QUERY, 8'hFF, 1'b1, 4'h0);
    endtask

    task automatic test_nested_service();
        send_event(ACT_PEND, LEGAL_MIN, 1'b1, 4'h0);
        send_event(ACT_PEND, 8'hFF, 1'b1, 4'h0);
        send_event(ACT_PEND, 8'h20, 1'b1, 4'h0);
        send_event(ACT_PEND, 8'hFF, 1'b1, 4'h0);
        send_event(ACT_ACK, 8'h00, 1'b0, 4'h0);
        send_event(ACT_ACK, 8'h00, 1'b1, 4'hF);
        send_event(ACT_ACK, 8'h00, 1'b1, 4'h0);
        // blocked by the class in service
        send_event(ACT_ACK, 8'h00, 1'b1, 4'h0);
        send_event(ACT_QUERY, 8'hF0, 1'b1, 4'h0);
        send_event(ACT_EOI, 8'h00, 1'b1, 4'h0);
        send_event(ACT_ACK, 8'h00, 1'b1, 4'h1);
        send_event(ACT_ACK, 8'h00, 1'b1, 4'h0);
        send_event(ACT_EOI, 8'h00, 1'b0, 4'hF);
        send_event(ACT_ACK, 8'h00, 1'b1, 4'h0);
        send_event(ACT_EOI, 8'h00, 1'b1, 4'h0);
        send_event(ACT_EOI, 8'h00, 1'b1, 4'h0);
    endtask

    task automatic test_illegal_pend();
        send_event(ACT_PEND, 8'h00, 1'b0, 4'h0);
        send_event(ACT_PEND, 8'h0F, 1'b1, 4'hF);
        send_event(ACT_QUERY, 8'h00, 1'b1, 4'h0);
    endtask

    task automatic test_random_traffic(int count, bit with_idle);
        action_t    act;
        logic [7:0] vec;
        logic       ie;
        logic [3:0] tpr;
        int         pick;
        idle_enabled = with_idle;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(99) < 85)
            begin
                // plausible traffic: mostly legal vectors and low task priority
                pick = $urandom_range(99);
                if (pick < 35)
                    act = ACT_PEND;
                else if (pick < 65)
                    act = ACT_ACK;
                else if (pick < 85)
                    act = ACT_EOI;
                else
                    act = ACT_QUERY;
                if ($urandom_range(19) == 0)
                    vec = 8'($urandom_range(15));
                else
                    vec = 8'($urandom_range(255, 16));
                ie = ($urandom_range(9) != 0);
                if ($urandom_range(3) == 0)
                    tpr = 4'($urandom_range(15));
                else
                    tpr = 4'($urandom_range(2));
            end
            else
            begin
                act = action_t'($urandom_range(3));
                vec = 8'($urandom);
                ie = 1'($urandom);
                tpr = 4'($urandom);
            end
            send_event(act, vec, ie, tpr);
        end
    endtask

    always @(posedge clk)
    begin : result_check
        outcome_t want;
        outcome_t got;
        if (rst_n && done)
        begin
            got = {delivered, delivered_vector, would_accept, illegal_vector_seen,
                   pending_any, highest_pending, in_service_any, highest_in_service};
            if (outcomes_in_flight.size() == 0)
            begin
                error_count++;
                if (report_count < MAX_REPORTS)
                    $display("unexpected result at cycle %0d", cycle_count);
                report_count++;
            end
            else
            begin
                want = outcomes_in_flight.pop_front();
                checked_count++;
                if (want.delivered)
                    delivery_count++;
                if (want.accept)
                    accept_count++;
                if (got !== want)
                begin
                    error_count++;
                    if (report_count < MAX_REPORTS)
                        $display("result %0d: want dlv=%b/%h acc=%b err=%b pnd=%b/%h srv=%b/%h, %s",
                                 checked_count, want.delivered, want.dvec, want.accept,
                                 want.err, want.pend_any, want.top_pend, want.srv_any,
                                 want.top_srv,
                                 $sformatf("got dlv=%b/%h acc=%b err=%b pnd=%b/%h srv=%b/%h",
                                           got.delivered, got.dvec, got.accept, got.err,
                                           got.pend_any, got.top_pend, got.srv_any,
                                           got.top_srv));
                    report_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout with %0d results outstanding", outcomes_in_flight.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        action = ACT_PEND;
        vector = 8'h00;
        interrupts_enabled = 1'b0;
        task_priority = 4'h0;
        request_map = '0;
        service_map = '0;
        err_sticky = 1'b0;
        sent_count = 0;
        checked_count = 0;
        delivery_count = 0;
        accept_count = 0;
        error_count = 0;
        report_count = 0;
        cycle_count = 0;
        idle_enabled = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_empty_events();
        test_nested_service();
        test_illegal_pend();
        test_random_traffic(600, 1'b1);
        // back-to-back stretch
        test_random_traffic(400, 1'b0);
        test_random_traffic(700, 1'b1);
        start = 1'b0;

        while (outcomes_in_flight.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
        error_count += outcomes_in_flight.size();

        $display("%0d events sent, %0d results checked in %0d cycles",
                 sent_count, checked_count, cycle_count);
        $display("%0d interrupts delivered, %0d queries accepted",
                 delivery_count, accept_count);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
